FILE: rtl/core/bac_pkg.sv
// Shared types, constants and register codes of the barometric altitude conditioner.
package bac_pkg;

  localparam int unsigned ALT_W    = 24;
  localparam int unsigned DT_W     = 20;
  localparam int unsigned VEL_W    = 16;
  localparam int unsigned CLIMB_W  = 32;
  localparam int unsigned LIMIT_W  = 10;
  localparam int unsigned BAND_W   = 8;
  localparam int unsigned STUCK_W  = 8;
  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CS_W     = 21;
  localparam int unsigned MUL_A_W  = 36;
  localparam int unsigned MUL_B_W  = 21;
  localparam int unsigned MUL_P_W  = MUL_A_W + MUL_B_W;

  localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST    = 10'd500;
  localparam logic [BAND_W-1:0]  SPEED_DEADBAND_RST = 8'd20;
  localparam logic [STUCK_W-1:0] STUCK_LIMIT_RST    = 8'd20;

  localparam logic signed [MUL_B_W-1:0] K_OLD      = 21'sd42598;
  localparam logic signed [MUL_B_W-1:0] K_NEW      = 21'sd22938;
  localparam logic signed [MUL_B_W-1:0] RECIP_20   = 21'sd3277;
  localparam logic signed [MUL_B_W-1:0] USEC_PER_S = 21'sd1000000;

  localparam logic signed [ALT_W-1:0]   ALT_MAX   = 24'sh7FFFFF;
  localparam logic signed [ALT_W-1:0]   ALT_MIN   = 24'sh800000;
  localparam logic signed [CLIMB_W-1:0] CLIMB_MAX = 32'sh7FFFFFFF;
  localparam logic signed [CLIMB_W-1:0] CLIMB_MIN = 32'sh80000000;

  typedef enum logic [1:0] {
    REG_SPEED_LIMIT    = 2'd0,
    REG_SPEED_DEADBAND = 2'd1,
    REG_STUCK_LIMIT    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [LIMIT_W-1:0] speed_limit;
    logic [BAND_W-1:0]  speed_deadband;
    logic [STUCK_W-1:0] stuck_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_OFFS,
    ST_SQX,
    ST_SQY,
    ST_SQRT,
    ST_SPD,
    ST_D20,
    ST_COMP,
    ST_ALT,
    ST_DIFF,
    ST_DIVI,
    ST_DIV,
    ST_FILA,
    ST_FILB,
    ST_FIN
  } bac_state_e;

endpackage

FILE: rtl/core/bac_cmpsub.sv
// Shared compare and subtract unit used by the square root and the divider.
module bac_cmpsub
  import bac_pkg::*;
(
  input  logic [CS_W-1:0] a_i,
  input  logic [CS_W-1:0] b_i,
  output logic            ge_o,
  output logic [CS_W-1:0] diff_o
);

  assign ge_o   = (a_i >= b_i);
  assign diff_o = a_i - b_i;

endmodule

FILE: rtl/core/bac_apb_regs.sv
// APB configuration registers of the barometric altitude conditioner.
module bac_apb_regs
  import bac_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t     cfg_q, cfg_d;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_SPEED_LIMIT:    cfg_d.speed_limit    = pwdata[LIMIT_W-1:0];
        REG_SPEED_DEADBAND: cfg_d.speed_deadband = pwdata[BAND_W-1:0];
        REG_STUCK_LIMIT:    cfg_d.stuck_limit    = pwdata[STUCK_W-1:0];
        default:            cfg_d                = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SPEED_LIMIT:    prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_q.speed_limit};
      REG_SPEED_DEADBAND: prdata = {{(DATA_W-BAND_W){1'b0}}, cfg_q.speed_deadband};
      REG_STUCK_LIMIT:    prdata = {{(DATA_W-STUCK_W){1'b0}}, cfg_q.stuck_limit};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speed_limit    <= SPEED_LIMIT_RST;
      cfg_q.speed_deadband <= SPEED_DEADBAND_RST;
      cfg_q.stuck_limit    <= STUCK_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/core/bac_datapath.sv
// Sequencer and datapath of the conditioner: offset, speed compensation, filters.
module bac_datapath
  import bac_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [ALT_W-1:0]   raw_altitude_i,
  input  logic [DT_W-1:0]           elapsed_us_i,
  input  logic                      warmup_done_i,
  input  logic                      gps_fixed_i,
  input  logic signed [VEL_W-1:0]   speed_x_i,
  input  logic signed [VEL_W-1:0]   speed_y_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [ALT_W-1:0]   altitude_o,
  output logic signed [CLIMB_W-1:0] climb_rate_q16_o,
  output logic                      sensor_fault_o
);

  bac_state_e state_q, state_d;

  logic signed [ALT_W-1:0]   raw_q, raw_d;
  logic [DT_W-1:0]           dt_q, dt_d;
  logic                      warm_q, warm_d;
  logic                      gps_q, gps_d;
  logic signed [VEL_W-1:0]   vx_q, vx_d, vy_q, vy_d;

  logic signed [ALT_W-1:0]   zo_q, zo_d, fa_q, fa_d, prev_q, prev_d;
  logic signed [CLIMB_W-1:0] climb_q, climb_d;
  logic [STUCK_W-1:0]        same_q, same_d;
  logic                      fault_q, fault_d;

  logic signed [ALT_W+1:0]   dv_q, dv_d;
  logic [31:0]               sq_q, sq_d;
  logic [15:0]               root_q, root_d;
  logic [DT_W-1:0]           rem_q, rem_d;
  logic [5:0]                cnt_q, cnt_d;
  logic [LIMIT_W-1:0]        sp_q, sp_d;
  logic signed [MUL_P_W-1:0] prod_q, prod_d;
  logic signed [ALT_W-1:0]   alt_q, alt_d;
  logic                      neg_q, neg_d;
  logic                      rsat_q, rsat_d;
  logic [34:0]               nq_q, nq_d;

  logic                      ov_q, ov_d;
  logic signed [ALT_W-1:0]   oalt_q, oalt_d;
  logic signed [CLIMB_W-1:0] oclimb_q, oclimb_d;
  logic                      ofault_q, ofault_d;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] mul_p;
  logic [CS_W-1:0]           cs_a, cs_b, cs_diff;
  logic                      cs_ge;

  logic signed [ALT_W:0]     off_sum, off_half;
  logic signed [ALT_W-1:0]   new_off;
  logic [LIMIT_W-1:0]        sp_clamp;
  logic [5:0]                q20;
  logic [LIMIT_W-1:0]        q20x20;
  logic signed [30:0]        dx, tcomp;
  logic signed [ALT_W+2:0]   alt_sum, alt_half;
  logic signed [ALT_W:0]     diff;
  logic [ALT_W:0]            mag;
  logic [25:0]               div_hi;
  logic signed [MUL_A_W-1:0] rate;
  logic signed [MUL_P_W-1:0] acc_r;
  logic signed [MUL_P_W-17:0] acc_sh;
  logic signed [CLIMB_W-1:0] climb_n;
  logic [STUCK_W-1:0]        same_n;
  logic                      fault_n;
  logic                      eq_alt;

  assign mul_p = mul_a * mul_b;

  bac_cmpsub u_cmpsub (
    .a_i    (cs_a),
    .b_i    (cs_b),
    .ge_o   (cs_ge),
    .diff_o (cs_diff)
  );

  assign in_ready_o       = (state_q == ST_IDLE);
  assign out_valid_o      = ov_q;
  assign altitude_o       = oalt_q;
  assign climb_rate_q16_o = oclimb_q;
  assign sensor_fault_o   = ofault_q;

  always_comb begin
    off_sum  = $signed({zo_q[ALT_W-1], zo_q}) + $signed({raw_q[ALT_W-1], raw_q});
    off_half = (off_sum + $signed({{ALT_W{1'b0}}, off_sum[ALT_W]})) >>> 1;
    new_off  = warm_q ? off_half[ALT_W-1:0] : zo_q;

    sp_clamp = (root_q > {6'd0, cfg_i.speed_limit}) ? cfg_i.speed_limit : root_q[LIMIT_W-1:0];

    q20    = prod_q[21:16];
    q20x20 = {q20, 4'd0} + {2'd0, q20, 2'd0};
    dx     = {{5{dv_q[ALT_W+1]}}, dv_q};
    tcomp  = (dx <<< 4) + (dx <<< 2) - $signed({21'd0, sp_q});

    alt_sum  = $signed({{3{fa_q[ALT_W-1]}}, fa_q}) + $signed({dv_q[ALT_W+1], dv_q});
    alt_half = (alt_sum + $signed({{(ALT_W+2){1'b0}}, alt_sum[ALT_W+2]})) >>> 1;

    diff   = $signed({alt_q[ALT_W-1], alt_q}) - $signed({prev_q[ALT_W-1], prev_q});
    mag    = diff[ALT_W] ? (ALT_W+1)'(0) - diff : diff;
    div_hi = prod_q[44:19];

    rate   = neg_q ? -$signed({1'b0, nq_q}) : $signed({1'b0, nq_q});
    acc_r  = prod_q + (prod_q[MUL_P_W-1] ? $signed(MUL_P_W'(65535)) : $signed(MUL_P_W'(0)));
    acc_sh = acc_r[MUL_P_W-1:16];
    if (rsat_q) begin
      climb_n = neg_q ? CLIMB_MIN : CLIMB_MAX;
    end else if (acc_sh > $signed({{(MUL_P_W-16-CLIMB_W){1'b0}}, CLIMB_MAX})) begin
      climb_n = CLIMB_MAX;
    end else if (acc_sh < $signed({{(MUL_P_W-16-CLIMB_W){1'b1}}, CLIMB_MIN})) begin
      climb_n = CLIMB_MIN;
    end else begin
      climb_n = acc_sh[CLIMB_W-1:0];
    end

    eq_alt = (alt_q == prev_q);
    if (eq_alt) begin
      same_n  = (same_q == '1) ? same_q : same_q + 1'b1;
      fault_n = fault_q || (same_n > cfg_i.stuck_limit);
    end else begin
      same_n  = '0;
      fault_n = 1'b0;
    end
  end

  always_comb begin
    state_d  = state_q;
    raw_d    = raw_q;
    dt_d     = dt_q;
    warm_d   = warm_q;
    gps_d    = gps_q;
    vx_d     = vx_q;
    vy_d     = vy_q;
    zo_d     = zo_q;
    fa_d     = fa_q;
    prev_d   = prev_q;
    climb_d  = climb_q;
    same_d   = same_q;
    fault_d  = fault_q;
    dv_d     = dv_q;
    sq_d     = sq_q;
    root_d   = root_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    sp_d     = sp_q;
    prod_d   = prod_q;
    alt_d    = alt_q;
    neg_d    = neg_q;
    rsat_d   = rsat_q;
    nq_d     = nq_q;
    ov_d     = ov_q && !out_ready_i;
    oalt_d   = oalt_q;
    oclimb_d = oclimb_q;
    ofault_d = ofault_q;
    mul_a    = '0;
    mul_b    = '0;
    cs_a     = '0;
    cs_b     = '0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          raw_d   = raw_altitude_i;
          dt_d    = (elapsed_us_i == '0) ? DT_W'(1) : elapsed_us_i;
          warm_d  = warmup_done_i;
          gps_d   = gps_fixed_i;
          vx_d    = speed_x_i;
          vy_d    = speed_y_i;
          rsat_d  = 1'b0;
          state_d = ST_OFFS;
        end
      end
      ST_OFFS: begin
        zo_d    = new_off;
        dv_d    = $signed({{2{raw_q[ALT_W-1]}}, raw_q}) - $signed({{2{new_off[ALT_W-1]}}, new_off});
        state_d = gps_q ? ST_SQX : ST_ALT;
      end
      ST_SQX: begin
        mul_a   = MUL_A_W'(vx_q);
        mul_b   = MUL_B_W'(vx_q);
        prod_d  = mul_p;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        mul_a   = MUL_A_W'(vy_q);
        mul_b   = MUL_B_W'(vy_q);
        sq_d    = prod_q[31:0] + mul_p[31:0];
        root_d  = '0;
        rem_d   = '0;
        cnt_d   = 6'd15;
        state_d = ST_SQRT;
      end
      ST_SQRT: begin
        cs_a   = {rem_q[18:0], sq_q[31:30]};
        cs_b   = {3'd0, root_q, 2'b01};
        rem_d  = cs_ge ? cs_diff[DT_W-1:0] : cs_a[DT_W-1:0];
        root_d = {root_q[14:0], cs_ge};
        sq_d   = {sq_q[29:0], 2'b00};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_SPD;
        end
      end
      ST_SPD: begin
        sp_d    = (sp_clamp > {2'd0, cfg_i.speed_deadband})
                  ? sp_clamp - {2'd0, cfg_i.speed_deadband} : '0;
        state_d = ST_D20;
      end
      ST_D20: begin
        mul_a   = $signed({{(MUL_A_W-LIMIT_W){1'b0}}, sp_q});
        mul_b   = RECIP_20;
        prod_d  = mul_p;
        state_d = ST_COMP;
      end
      ST_COMP: begin
        dv_d    = dv_q - $signed({{(ALT_W-4){1'b0}}, q20})
                  - $signed({{(ALT_W+1){1'b0}}, (!tcomp[30] && (sp_q != q20x20))});
        state_d = ST_ALT;
      end
      ST_ALT: begin
        if (alt_half > $signed({{3{1'b0}}, ALT_MAX})) begin
          alt_d = ALT_MAX;
        end else if (alt_half < $signed({{3{1'b1}}, ALT_MIN})) begin
          alt_d = ALT_MIN;
        end else begin
          alt_d = alt_half[ALT_W-1:0];
        end
        state_d = ST_DIFF;
      end
      ST_DIFF: begin
        neg_d   = diff[ALT_W];
        mul_a   = $signed({{(MUL_A_W-ALT_W-1){1'b0}}, mag});
        mul_b   = USEC_PER_S;
        prod_d  = mul_p;
        state_d = ST_DIVI;
      end
      ST_DIVI: begin
        rsat_d = (div_hi >= {6'd0, dt_q});
        rem_d  = div_hi[DT_W-1:0];
        nq_d   = {prod_q[18:0], 16'd0};
        cnt_d  = 6'd34;
        state_d = (div_hi >= {6'd0, dt_q}) ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cs_a  = {rem_q, nq_q[34]};
        cs_b  = {1'b0, dt_q};
        rem_d = cs_ge ? cs_diff[DT_W-1:0] : cs_a[DT_W-1:0];
        nq_d  = {nq_q[33:0], cs_ge};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = ST_FILA;
        end
      end
      ST_FILA: begin
        mul_a   = MUL_A_W'(climb_q);
        mul_b   = K_OLD;
        prod_d  = mul_p;
        state_d = ST_FILB;
      end
      ST_FILB: begin
        mul_a   = rate;
        mul_b   = K_NEW;
        prod_d  = prod_q + mul_p;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!ov_q || out_ready_i) begin
          fa_d     = alt_q;
          prev_d   = alt_q;
          climb_d  = climb_n;
          same_d   = same_n;
          fault_d  = fault_n;
          ov_d     = 1'b1;
          oalt_d   = alt_q;
          oclimb_d = climb_n;
          ofault_d = fault_n;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      zo_q    <= '0;
      fa_q    <= '0;
      prev_q  <= '0;
      climb_q <= '0;
      same_q  <= '0;
      fault_q <= 1'b0;
      ov_q    <= 1'b0;
      rsat_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      zo_q    <= zo_d;
      fa_q    <= fa_d;
      prev_q  <= prev_d;
      climb_q <= climb_d;
      same_q  <= same_d;
      fault_q <= fault_d;
      ov_q    <= ov_d;
      rsat_q  <= rsat_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_q    <= raw_d;
    dt_q     <= dt_d;
    warm_q   <= warm_d;
    gps_q    <= gps_d;
    vx_q     <= vx_d;
    vy_q     <= vy_d;
    dv_q     <= dv_d;
    sq_q     <= sq_d;
    root_q   <= root_d;
    rem_q    <= rem_d;
    sp_q     <= sp_d;
    prod_q   <= prod_d;
    alt_q    <= alt_d;
    neg_q    <= neg_d;
    nq_q     <= nq_d;
    oalt_q   <= oalt_d;
    oclimb_q <= oclimb_d;
    ofault_q <= ofault_d;
  end

endmodule

FILE: rtl/core/baro_altitude_conditioner_top.sv
// Barometric altitude conditioner: one sample in, one conditioned result out, processed
// one sample at a time. The 16 steps of the speed square root and the 35 steps of the
// vertical speed division share one compare and subtract unit. When the vertical speed is
// so large that the climb rate saturates, the division and the climb filter are skipped.
// The input is not ready while a sample is being processed and becomes ready again
// together with the result, so a new sample is taken only once the last one is through.
// A finished result waits in an output register, so the next sample may be taken before
// it is collected. Configuration registers lie at byte addresses 0, 4 and 8; the user
// must write them only while the block is idle, which the block itself does not enforce.
module baro_altitude_conditioner_top
  import bac_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [ALT_W-1:0]   raw_altitude_i,
  input  logic [DT_W-1:0]           elapsed_us_i,
  input  logic                      warmup_done_i,
  input  logic                      gps_fixed_i,
  input  logic signed [VEL_W-1:0]   speed_x_i,
  input  logic signed [VEL_W-1:0]   speed_y_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic signed [ALT_W-1:0]   altitude_o,
  output logic signed [CLIMB_W-1:0] climb_rate_q16_o,
  output logic                      sensor_fault_o
);

  cfg_t cfg;

  bac_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bac_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .raw_altitude_i   (raw_altitude_i),
    .elapsed_us_i     (elapsed_us_i),
    .warmup_done_i    (warmup_done_i),
    .gps_fixed_i      (gps_fixed_i),
    .speed_x_i        (speed_x_i),
    .speed_y_i        (speed_y_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .altitude_o       (altitude_o),
    .climb_rate_q16_o (climb_rate_q16_o),
    .sensor_fault_o   (sensor_fault_o)
  );

  a_busy_after_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o ##1 !in_ready_o)
    else $error("input ready too soon after a transfer");

  a_result_from_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a sample in progress");

  a_stuck_limit_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && (paddr[3:2] == 2'(REG_STUCK_LIMIT)))
    |=> (cfg.stuck_limit == $past(pwdata[STUCK_W-1:0])))
    else $error("stuck limit register not written");

endmodule

FILE: tb/bac_checker.sv
// Watcher for the altitude conditioner: predicts each result and compares every output transfer.
`timescale 1ns / 100ps

module bac_checker
  import bac_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic                      pready_i,
  input  logic [ADDR_W-1:0]         paddr_i,
  input  logic [DATA_W-1:0]         pwdata_i,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  logic signed [ALT_W-1:0]   raw_altitude_i,
  input  logic [DT_W-1:0]           elapsed_us_i,
  input  logic                      warmup_done_i,
  input  logic                      gps_fixed_i,
  input  logic signed [VEL_W-1:0]   speed_x_i,
  input  logic signed [VEL_W-1:0]   speed_y_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  logic signed [ALT_W-1:0]   altitude_i,
  input  logic signed [CLIMB_W-1:0] climb_rate_q16_i,
  input  logic                      sensor_fault_i,
  output int unsigned               mismatch_count_o,
  output int unsigned               outstanding_o
);

  localparam longint RATE_BOUND = 64'sd1099511627776;

  typedef struct packed {
    logic signed [ALT_W-1:0]   altitude;
    logic signed [CLIMB_W-1:0] climb;
    logic                      fault;
  } conditioned_t;

  conditioned_t awaited_q[$];

  logic [LIMIT_W-1:0]         limit_cfg;
  logic [BAND_W-1:0]          band_cfg;
  logic [STUCK_W-1:0]         stuck_cfg;
  logic signed [ALT_W-1:0]    offset_cm;
  logic signed [ALT_W-1:0]    filt_cm;
  logic signed [ALT_W-1:0]    prev_cm;
  logic signed [CLIMB_W-1:0]  climb_state;
  logic [7:0]                 same_run;
  logic                       stuck_flag;
  int unsigned                mismatches = 0;
  int unsigned                results_seen = 0;

  assign mismatch_count_o = mismatches;

  function automatic longint floor_root(input longint radicand);
    longint root;
    longint trial;
    root = 0;
    for (int b = 16; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= radicand) root = trial;
    end
    return root;
  endfunction

  function automatic conditioned_t condition_sample(
    input logic signed [ALT_W-1:0] raw,
    input logic [DT_W-1:0]         elapsed,
    input logic                    warm,
    input logic                    gps,
    input logic signed [VEL_W-1:0] vx,
    input logic signed [VEL_W-1:0] vy
  );
    longint       d;
    longint       alt;
    longint       speed;
    longint       divisor;
    longint       rate;
    longint       acc;
    conditioned_t res;
    if (warm) offset_cm = ALT_W'((longint'(offset_cm) + longint'(raw)) / 2);
    d = longint'(raw) - longint'(offset_cm);
    if (gps) begin
      speed = floor_root(longint'(vx) * longint'(vx) + longint'(vy) * longint'(vy));
      if (speed > longint'(limit_cfg)) speed = longint'(limit_cfg);
      speed = (speed > longint'(band_cfg)) ? speed - longint'(band_cfg) : 0;
      d = (d * 20 - speed) / 20;
    end
    alt = (longint'(filt_cm) + d) / 2;
    if (alt > longint'(ALT_MAX)) alt = longint'(ALT_MAX);
    if (alt < longint'(ALT_MIN)) alt = longint'(ALT_MIN);
    filt_cm = ALT_W'(alt);
    divisor = (elapsed == '0) ? 1 : longint'(elapsed);
    rate = ((alt - longint'(prev_cm)) * 1000000 * 65536) / divisor;
    if (rate > RATE_BOUND) rate = RATE_BOUND;
    if (rate < -RATE_BOUND) rate = -RATE_BOUND;
    acc = (longint'(climb_state) * longint'(K_OLD) + rate * longint'(K_NEW)) / 65536;
    if (acc > longint'(CLIMB_MAX)) acc = longint'(CLIMB_MAX);
    if (acc < longint'(CLIMB_MIN)) acc = longint'(CLIMB_MIN);
    climb_state = CLIMB_W'(acc);
    if (alt == longint'(prev_cm)) begin
      if (same_run != 8'hFF) same_run++;
      if (same_run > stuck_cfg) stuck_flag = 1'b1;
    end else begin
      same_run = '0;
      stuck_flag = 1'b0;
    end
    prev_cm = ALT_W'(alt);
    res.altitude = ALT_W'(alt);
    res.climb = climb_state;
    res.fault = stuck_flag;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    conditioned_t awaited;
    if (!rst_ni) begin
      awaited_q.delete();
      limit_cfg = SPEED_LIMIT_RST;
      band_cfg = SPEED_DEADBAND_RST;
      stuck_cfg = STUCK_LIMIT_RST;
      offset_cm = '0;
      filt_cm = '0;
      prev_cm = '0;
      climb_state = '0;
      same_run = '0;
      stuck_flag = 1'b0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen++;
        if (awaited_q.size() == 0) begin
          if (mismatches < 10)
            $display("result %0d arrived with nothing awaited", results_seen);
          mismatches++;
        end else begin
          awaited = awaited_q.pop_front();
          if (awaited.altitude !== altitude_i || awaited.climb !== climb_rate_q16_i ||
              awaited.fault !== sensor_fault_i) begin
            if (mismatches < 10)
              $display("result %0d: altitude %0d expected %0d, climb %0d expected %0d, %s%0b %s%0b",
                       results_seen, $signed(altitude_i), $signed(awaited.altitude),
                       $signed(climb_rate_q16_i), $signed(awaited.climb),
                       "fault ", sensor_fault_i, "expected ", awaited.fault);
            mismatches++;
          end
        end
      end
      if (in_valid_i && in_ready_i)
        awaited_q.push_back(condition_sample(raw_altitude_i, elapsed_us_i, warmup_done_i,
                                             gps_fixed_i, speed_x_i, speed_y_i));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[ADDR_W-1:2])
          REG_SPEED_LIMIT:    limit_cfg = pwdata_i[LIMIT_W-1:0];
          REG_SPEED_DEADBAND: band_cfg = pwdata_i[BAND_W-1:0];
          REG_STUCK_LIMIT:    stuck_cfg = pwdata_i[STUCK_W-1:0];
          default: ;
        endcase
      end
      outstanding_o <= awaited_q.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the altitude conditioner testbench: clock, reset, stimulus, configuration and verdict.
`timescale 1ns / 100ps

module testbench;
  import bac_pkg::*;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [ADDR_W-1:0]         paddr;
  logic [DATA_W-1:0]         pwdata;
  logic [DATA_W-1:0]         prdata;
  logic                      pready;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic signed [ALT_W-1:0]   raw_altitude_i;
  logic [DT_W-1:0]           elapsed_us_i;
  logic                      warmup_done_i;
  logic                      gps_fixed_i;
  logic signed [VEL_W-1:0]   speed_x_i;
  logic signed [VEL_W-1:0]   speed_y_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [ALT_W-1:0]   altitude_o;
  logic signed [CLIMB_W-1:0] climb_rate_q16_o;
  logic                      sensor_fault_o;
  int unsigned               mismatch_count;
  int unsigned               outstanding;
  bit                        idle_on = 1'b1;

  baro_altitude_conditioner_top dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .raw_altitude_i, .elapsed_us_i, .warmup_done_i,
    .gps_fixed_i, .speed_x_i, .speed_y_i, .out_valid_o, .out_ready_i, .altitude_o,
    .climb_rate_q16_o, .sensor_fault_o
  );

  bac_checker u_watch (
    .clk_i, .rst_ni,
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .pready_i(pready),
    .paddr_i(paddr), .pwdata_i(pwdata),
    .in_valid_i, .in_ready_i(in_ready_o), .raw_altitude_i, .elapsed_us_i,
    .warmup_done_i, .gps_fixed_i, .speed_x_i, .speed_y_i,
    .out_valid_i(out_valid_o), .out_ready_i, .altitude_i(altitude_o),
    .climb_rate_q16_i(climb_rate_q16_o), .sensor_fault_i(sensor_fault_o),
    .mismatch_count_o(mismatch_count), .outstanding_o(outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #6000000;
    $display("baro_altitude_conditioner_top: mismatch");
    $finish;
  end

  // The result side stalls in random bursts while idling is on, so that transfers meet back-pressure.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  function automatic logic signed [ALT_W-1:0] pick_altitude();
    case ($urandom_range(0, 7))
      0:       return ALT_MAX;
      1:       return ALT_MIN;
      2, 3:    return ALT_W'($urandom);
      default: return ALT_W'(int'($urandom_range(0, 4000)) - 2000);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] pick_elapsed();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return DT_W'($urandom);
      3:       return DT_W'($urandom_range(1, 100));
      default: return DT_W'($urandom_range(1, 1000000));
    endcase
  endfunction

  function automatic logic signed [VEL_W-1:0] pick_speed();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 1) ? VEL_W'(32767) : VEL_W'(-32768);
      1:       return VEL_W'($urandom);
      default: return VEL_W'(int'($urandom_range(0, 1200)) - 600);
    endcase
  endfunction

  task automatic send_sample(
    input logic signed [ALT_W-1:0] raw,
    input logic [DT_W-1:0]         dt,
    input logic                    warm,
    input logic                    gps,
    input logic signed [VEL_W-1:0] vx,
    input logic signed [VEL_W-1:0] vy
  );
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    raw_altitude_i <= raw;
    elapsed_us_i <= dt;
    warmup_done_i <= warm;
    gps_fixed_i <= gps;
    speed_x_i <= vx;
    speed_y_i <= vy;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic sample_run(input int unsigned len);
    logic signed [ALT_W-1:0] raw;
    logic                    warm;
    logic                    gps;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    raw = pick_altitude();
    warm = 1'($urandom_range(0, 1));
    gps = 1'($urandom_range(0, 1));
    vx = pick_speed();
    vy = pick_speed();
    repeat (len) send_sample(raw, pick_elapsed(), warm, gps, vx, vy);
  endtask

  task automatic random_samples(input int unsigned count);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 4) == 0) begin
        send_sample(pick_altitude(), pick_elapsed(), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)), pick_speed(), pick_speed());
        sent++;
      end else begin
        len = $urandom_range(1, 40);
        sample_run(len);
        sent += len;
      end
    end
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input int unsigned value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(int'(idx) * 4);
    pwdata <= DATA_W'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
  endtask

  task automatic reconfigure(input int unsigned limit_val, input int unsigned band_val,
                             input int unsigned stuck_val, input bit with_idle);
    settle();
    write_reg(REG_SPEED_LIMIT, limit_val);
    write_reg(REG_SPEED_DEADBAND, band_val);
    write_reg(REG_STUCK_LIMIT, stuck_val);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    idle_on = with_idle;
  endtask

  initial begin
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    raw_altitude_i <= '0;
    elapsed_us_i <= '0;
    warmup_done_i <= 1'b0;
    gps_fixed_i <= 1'b0;
    speed_x_i <= '0;
    speed_y_i <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_sample(ALT_MAX, 1, 1'b0, 1'b0, 0, 0);
    send_sample(ALT_MIN, 1, 1'b0, 1'b0, 0, 0);
    send_sample(0, 0, 1'b0, 1'b0, 0, 0);
    send_sample(0, '1, 1'b0, 1'b0, 0, 0);
    send_sample(100, 1000000, 1'b0, 1'b1, VEL_W'(-32768), VEL_W'(-32768));
    send_sample(100, 20000, 1'b0, 1'b1, VEL_W'(32767), 0);
    send_sample(-100, 20000, 1'b0, 1'b1, 3, 4);
    send_sample(0, 20000, 1'b0, 1'b1, 0, 0);
    send_sample(5, 20000, 1'b0, 1'b1, -300, 400);
    send_sample(ALT_MIN, 50000, 1'b1, 1'b0, 0, 0);
    repeat (4) send_sample(ALT_MAX, 1, 1'b0, 1'b0, 0, 0);
    repeat (3) send_sample(ALT_MAX, 10, 1'b1, 1'b0, 0, 0);
    repeat (3) send_sample(ALT_MIN, 1, 1'b0, 1'b0, 0, 0);
    send_sample(0, 1, 1'b1, 1'b1, VEL_W'(32767), VEL_W'(-32768));
    send_sample(-1, 999, 1'b1, 1'b1, -1, -1);

    reconfigure(1000, 0, 0, 1'b1);
    random_samples(220);
    reconfigure(0, 255, 255, 1'b1);
    sample_run(300);
    random_samples(60);
    reconfigure($urandom_range(0, 1000), $urandom_range(0, 255), $urandom_range(0, 40), 1'b1);
    random_samples(220);
    reconfigure(300, 255, 3, 1'b1);
    random_samples(200);
    reconfigure($urandom_range(0, 1000), $urandom_range(0, 255), $urandom_range(0, 10), 1'b0);
    random_samples(150);

    settle();
    repeat (80) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("baro_altitude_conditioner_top: match");
    end else begin
      $display("baro_altitude_conditioner_top: mismatch");
    end
    $finish;
  end

endmodule
